// File: src/rss_pkg.sv
// Shared types and constants for the running sample statistics block.
// No dependencies; imported by every module of the block.
`default_nettype none
package rss_pkg;
	localparam int SAMPLE_W        = 16;
	localparam int CNT_W           = 16;
	localparam int SUM_W           = 32;
	localparam int SQ_W            = 46;
	localparam int MEAN_W          = 24;
	localparam int VAR_W           = 39;
	localparam int SD_W            = 24;
	localparam int FRAC_BITS       = 8;
	localparam int MAX_SAMPLES_DEF = 65535;
	localparam int DIV_W           = SQ_W + FRAC_BITS;
	localparam int DIV_CNT_W       = $clog2(DIV_W + 1);
	localparam int SQRT_VW         = VAR_W + FRAC_BITS;
	localparam int SQRT_W          = SQRT_VW + (SQRT_VW % 2);
	localparam int PROD_W          = 2 * MEAN_W;

	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MOST_POS = 16'sh7FFF;
	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MOST_NEG = 16'sh8000;

	typedef struct packed {
		logic [CNT_W-1:0]           cnt;
		logic signed [SUM_W-1:0]    sum;
		logic [SQ_W-1:0]            sq;
		logic signed [SAMPLE_W-1:0] min;
		logic signed [SAMPLE_W-1:0] max;
		logic                       ovf;
	} snap_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_DIV_MEAN,
		B_DIV_SQ,
		B_MUL,
		B_VAR,
		B_SQRT,
		B_OUT
	} back_state_t;
endpackage
`default_nettype wire

// File: src/rss_front.sv
// Front end: accumulates count, sums, min and max per sample set.
// Depends on rss_pkg; pushes a snapshot of each finished set to the queue.
`default_nettype none
module rss_front #(
	parameter int MAX_SAMPLES = rss_pkg::MAX_SAMPLES_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	input  wire logic                                q_full,
	input  wire logic signed [rss_pkg::SAMPLE_W-1:0] sample,
	input  wire logic                                last,
	output logic                                     in_stall,
	output logic                                     push,
	output rss_pkg::snap_t                           push_snap
);
	import rss_pkg::*;

	snap_t                acc_q;
	snap_t                acc_next;
	logic                 take;
	logic signed [31:0]   sq_prod;
	logic                 full;

	assign in_stall = q_full;
	assign take     = in_valid && !q_full;
	assign push     = take && last;
	assign sq_prod  = sample * sample;
	assign full     = acc_q.cnt >= CNT_W'(MAX_SAMPLES);

	always_comb begin
		acc_next = acc_q;
		if (full) begin
			acc_next.ovf = 1'b1;
		end else begin
			acc_next.cnt = acc_q.cnt + 1'b1;
			acc_next.sum = acc_q.sum + SUM_W'(sample);
			acc_next.sq  = acc_q.sq + SQ_W'(unsigned'(sq_prod));
			if (sample < acc_q.min) acc_next.min = sample;
			if (sample > acc_q.max) acc_next.max = sample;
		end
	end

	assign push_snap = acc_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '{cnt: '0, sum: '0, sq: '0, min: SAMPLE_MOST_POS,
				max: SAMPLE_MOST_NEG, ovf: 1'b0};
		end else if (take) begin
			if (last) begin
				acc_q <= '{cnt: '0, sum: '0, sq: '0, min: SAMPLE_MOST_POS,
					max: SAMPLE_MOST_NEG, ovf: 1'b0};
			end else begin
				acc_q <= acc_next;
			end
		end
	end
endmodule
`default_nettype wire

// File: src/rss_fifo.sv
// Two-entry queue of set snapshots between the front and back ends.
// Depends on rss_pkg for the snapshot type.
`default_nettype none
module rss_fifo (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire rss_pkg::snap_t push_snap,
	input  wire logic           pop,
	output logic                full,
	output logic                empty,
	output rss_pkg::snap_t      pop_snap
);
	import rss_pkg::*;

	snap_t       mem [2];
	logic        wr_q;
	logic        rd_q;
	logic [1:0]  fill_q;

	assign full     = fill_q == 2'd2;
	assign empty    = fill_q == 2'd0;
	assign pop_snap = mem[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem[wr_q] <= push_snap;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= 1'b0;
			rd_q   <= 1'b0;
			fill_q <= 2'd0;
		end else begin
			if (push) wr_q <= !wr_q;
			if (pop) rd_q <= !rd_q;
			fill_q <= fill_q + 2'(push) - 2'(pop);
		end
	end
endmodule
`default_nettype wire

// File: src/rss_back.sv
// Back end: shared bit-serial divider, variance and bit-serial square root.
// Depends on rss_pkg; holds the finished result until transferred.
`default_nettype none
module rss_back (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                q_empty,
	input  wire rss_pkg::snap_t                      q_snap,
	output logic                                     pop,
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output logic [rss_pkg::CNT_W-1:0]                count,
	output logic signed [rss_pkg::SUM_W-1:0]         total,
	output logic [rss_pkg::SQ_W-1:0]                 square_total,
	output logic signed [rss_pkg::SAMPLE_W-1:0]      minimum,
	output logic signed [rss_pkg::SAMPLE_W-1:0]      maximum,
	output logic signed [rss_pkg::MEAN_W-1:0]        mean,
	output logic [rss_pkg::VAR_W-1:0]                variance,
	output logic [rss_pkg::SD_W-1:0]                 std_dev,
	output logic                                     overflowed
);
	import rss_pkg::*;

	back_state_t          state_q, state_d;
	snap_t                snap_q;
	logic [CNT_W-1:0]     div_q;
	logic [DIV_W-1:0]     dvd_q;
	logic [DIV_W-1:0]     quo_q;
	logic [CNT_W:0]       rem_q;
	logic [DIV_CNT_W-1:0] step_q;
	logic [MEAN_W-1:0]    mabs_q;
	logic [MEAN_W-1:0]    mean_q;
	logic [VAR_W-1:0]     qsq_q;
	logic [PROD_W-1:0]    prod_q;
	logic [VAR_W-1:0]     var_q;
	logic [SQRT_W-1:0]    sqv_q;
	logic [SQRT_W-1:0]    root_q;
	logic [SQRT_W-1:0]    bit_q;

	logic [CNT_W:0]       trial;
	logic                 qbit;
	logic [CNT_W:0]       rem_next;
	logic [DIV_W-1:0]     quo_next;
	logic                 div_done;
	logic [SUM_W-1:0]     sum_mag;
	logic [MEAN_W-1:0]    mag_next;
	logic [PROD_W-1:0]    qsq_ext;
	logic [PROD_W-1:0]    msq;
	logic [SQRT_W-1:0]    root_bit;

	assign trial    = {rem_q[CNT_W-1:0], dvd_q[DIV_W-1]};
	assign qbit     = trial >= {1'b0, div_q};
	assign rem_next = qbit ? trial - {1'b0, div_q} : trial;
	assign quo_next = {quo_q[DIV_W-2:0], qbit};
	assign div_done = step_q == DIV_CNT_W'(DIV_W - 1);
	assign sum_mag  = q_snap.sum[SUM_W-1] ? SUM_W'(0) - unsigned'(q_snap.sum)
		: unsigned'(q_snap.sum);
	assign mag_next = quo_next[MEAN_W-1:0];
	assign qsq_ext  = PROD_W'(qsq_q);
	assign msq      = prod_q >> FRAC_BITS;
	assign root_bit = root_q + bit_q;

	always_comb begin
		state_d = state_q;
		pop     = 1'b0;
		unique case (state_q)
			B_IDLE: begin
				if (!q_empty) begin
					pop     = 1'b1;
					state_d = B_DIV_MEAN;
				end
			end
			B_DIV_MEAN: if (div_done) state_d = B_DIV_SQ;
			B_DIV_SQ:   if (div_done) state_d = B_MUL;
			B_MUL:      state_d = B_VAR;
			B_VAR:      state_d = B_SQRT;
			B_SQRT:     if (bit_q == '0) state_d = B_OUT;
			B_OUT:      if (!out_stall) state_d = B_IDLE;
			default:    state_d = B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= B_IDLE;
		else state_q <= state_d;
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			B_IDLE: begin
				snap_q <= q_snap;
				div_q  <= (q_snap.cnt == '0) ? CNT_W'(1) : q_snap.cnt;
				dvd_q  <= DIV_W'(sum_mag) << FRAC_BITS;
				quo_q  <= '0;
				rem_q  <= '0;
				step_q <= '0;
			end
			B_DIV_MEAN, B_DIV_SQ: begin
				dvd_q  <= dvd_q << 1;
				quo_q  <= quo_next;
				rem_q  <= rem_next;
				step_q <= step_q + 1'b1;
				if (div_done) begin
					step_q <= '0;
					rem_q  <= '0;
					quo_q  <= '0;
					if (state_q == B_DIV_MEAN) begin
						mabs_q <= mag_next;
						mean_q <= snap_q.sum[SUM_W-1] ? MEAN_W'(0) - mag_next : mag_next;
						dvd_q  <= DIV_W'(snap_q.sq) << FRAC_BITS;
					end else begin
						qsq_q <= quo_next[VAR_W-1:0];
					end
				end
			end
			B_MUL: prod_q <= mabs_q * mabs_q;
			B_VAR: begin
				var_q  <= (qsq_ext > msq) ? VAR_W'(qsq_ext - msq) : '0;
				sqv_q  <= (qsq_ext > msq) ? SQRT_W'(VAR_W'(qsq_ext - msq)) << FRAC_BITS
					: '0;
				root_q <= '0;
				bit_q  <= SQRT_W'(1) << (SQRT_W - 2);
			end
			B_SQRT: begin
				if (bit_q != '0) begin
					if (sqv_q >= root_bit) begin
						sqv_q  <= sqv_q - root_bit;
						root_q <= (root_q >> 1) + bit_q;
					end else begin
						root_q <= root_q >> 1;
					end
					bit_q <= bit_q >> 2;
				end
			end
			B_OUT: ;
			default: ;
		endcase
	end

	assign out_valid    = state_q == B_OUT;
	assign count        = snap_q.cnt;
	assign total        = snap_q.sum;
	assign square_total = snap_q.sq;
	assign minimum      = snap_q.min;
	assign maximum      = snap_q.max;
	assign mean         = mean_q;
	assign variance     = var_q;
	assign std_dev      = root_q[SD_W-1:0];
	assign overflowed   = snap_q.ovf;
endmodule
`default_nettype wire

// File: src/running_sample_statistics.sv
// Running sample statistics: one sample per cycle into the accumulator
// while in_stall is low (it rises when the queue is full). A set closed by
// last is finished by the back end: a one-bit-per-cycle divider run twice,
// then a two-bit-per-cycle square root. Two finished sets can queue behind it.
// Asynchronous active-low reset empties the queue and clears the set.
`default_nettype none
module running_sample_statistics #(
	parameter int MAX_SAMPLES = rss_pkg::MAX_SAMPLES_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_stall,
	input  wire logic signed [rss_pkg::SAMPLE_W-1:0] sample,
	input  wire logic                                last,
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output logic [rss_pkg::CNT_W-1:0]                count,
	output logic signed [rss_pkg::SUM_W-1:0]         total,
	output logic [rss_pkg::SQ_W-1:0]                 square_total,
	output logic signed [rss_pkg::SAMPLE_W-1:0]      minimum,
	output logic signed [rss_pkg::SAMPLE_W-1:0]      maximum,
	output logic signed [rss_pkg::MEAN_W-1:0]        mean,
	output logic [rss_pkg::VAR_W-1:0]                variance,
	output logic [rss_pkg::SD_W-1:0]                 std_dev,
	output logic                                     overflowed
);
	import rss_pkg::*;

	logic  push, pop, q_full, q_empty;
	snap_t push_snap, pop_snap;

	rss_front #(.MAX_SAMPLES(MAX_SAMPLES)) u_front (
		.clk, .arst_n, .in_valid, .q_full, .sample, .last,
		.in_stall, .push, .push_snap
	);

	rss_fifo u_fifo (
		.clk, .arst_n, .push, .push_snap, .pop,
		.full(q_full), .empty(q_empty), .pop_snap
	);

	rss_back u_back (
		.clk, .arst_n, .q_empty, .q_snap(pop_snap), .pop,
		.out_valid, .out_stall, .count, .total, .square_total,
		.minimum, .maximum, .mean, .variance, .std_dev, .overflowed
	);
endmodule
`default_nettype wire

// File: tb/sv/tb_running_sample_statistics.sv
// Testbench for running_sample_statistics: drives sample sets through the
// valid/stall channels and checks every result against an in-bench predictor or hand-typed expected values.
// Depends on rss_pkg and the running_sample_statistics RTL.
module tb_running_sample_statistics;
	import rss_pkg::*;

	localparam longint CYCLE_LIMIT = 3_000_000;
	localparam int     SET_FULL    = MAX_SAMPLES_DEF;

	typedef struct packed {
		logic [CNT_W-1:0]           count;
		logic signed [SUM_W-1:0]    total;
		logic [SQ_W-1:0]            square_total;
		logic signed [SAMPLE_W-1:0] minimum;
		logic signed [SAMPLE_W-1:0] maximum;
		logic signed [MEAN_W-1:0]   mean;
		logic [VAR_W-1:0]           variance;
		logic [SD_W-1:0]            std_dev;
		logic                       overflowed;
	} stats_t;

	typedef struct {
		logic signed [SAMPLE_W-1:0] s;
		logic                       l;
		bit                         typed;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [SAMPLE_W-1:0] sample = '0;
	logic last = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [CNT_W-1:0] count;
	logic signed [SUM_W-1:0] total;
	logic [SQ_W-1:0] square_total;
	logic signed [SAMPLE_W-1:0] minimum;
	logic signed [SAMPLE_W-1:0] maximum;
	logic signed [MEAN_W-1:0] mean;
	logic [VAR_W-1:0] variance;
	logic [SD_W-1:0] std_dev;
	logic overflowed;

	stats_t pending_stats[$];
	stats_t typed_stats[$];
	int     errors = 0;
	int     sets_checked = 0;
	int     samples_sent = 0;
	longint cycles = 0;
	bit     tx_idle_on = 1'b0;
	bit     rx_idle_on = 1'b0;
	int     stall_left = 0;

	// predictor state
	int                         acc_count;
	longint                     acc_sum;
	logic [46:0]                acc_sq;
	logic signed [SAMPLE_W-1:0] acc_min;
	logic signed [SAMPLE_W-1:0] acc_max;
	bit                         acc_ovf;

	running_sample_statistics DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .sample(sample), .last(last),
		.out_valid(out_valid), .out_stall(out_stall),
		.count(count), .total(total), .square_total(square_total),
		.minimum(minimum), .maximum(maximum), .mean(mean),
		.variance(variance), .std_dev(std_dev), .overflowed(overflowed)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [63:0] floor_root(logic [63:0] v);
		logic [63:0] r;
		logic [63:0] b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	task automatic clear_set();
		acc_count = 0;
		acc_sum = 0;
		acc_sq = '0;
		acc_min = SAMPLE_MOST_POS;
		acc_max = SAMPLE_MOST_NEG;
		acc_ovf = 1'b0;
	endtask

	task automatic absorb_sample(input logic signed [SAMPLE_W-1:0] s, input logic l,
			output bit closed, output stats_t res);
		longint n;
		longint avg;
		longint sv;
		logic [63:0] sq_avg;
		logic [63:0] avg_abs;
		logic [63:0] avg_sq;
		logic [63:0] spread;
		sv = s;
		closed = 1'b0;
		res = '0;
		if (acc_count >= SET_FULL) begin
			acc_ovf = 1'b1;
		end else begin
			acc_count++;
			acc_sum += sv;
			acc_sq = acc_sq + 47'(sv * sv);
			if (s < acc_min) acc_min = s;
			if (s > acc_max) acc_max = s;
		end
		if (!l) return;
		n = (acc_count == 0) ? 1 : acc_count;
		avg = (acc_sum * (64'sd1 <<< FRAC_BITS)) / n;
		sq_avg = ({17'd0, acc_sq} << FRAC_BITS) / 64'(n);
		avg_abs = (avg < 0) ? 64'(-avg) : 64'(avg);
		avg_sq = (avg_abs * avg_abs) >> FRAC_BITS;
		spread = (sq_avg > avg_sq) ? sq_avg - avg_sq : 64'd0;
		res.count = CNT_W'(acc_count);
		res.total = SUM_W'(acc_sum);
		res.square_total = SQ_W'(acc_sq);
		res.minimum = acc_min;
		res.maximum = acc_max;
		res.mean = MEAN_W'(avg);
		res.variance = VAR_W'(spread);
		res.std_dev = SD_W'(floor_root(spread << FRAC_BITS));
		res.overflowed = acc_ovf;
		closed = 1'b1;
		clear_set();
	endtask

	task automatic report(input string field, input longint got, input longint want);
		errors++;
		if (errors <= 30)
			$display("mismatch in %s: got %0d, want %0d", field, got, want);
	endtask

	task automatic send_sample(input logic signed [SAMPLE_W-1:0] s, input logic l,
			input bit use_typed);
		int gap;
		bit closed;
		stats_t res;
		gap = tx_idle_on ? $urandom_range(0, 16) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		sample <= s;
		last <= l;
		do @(posedge clk); while (in_stall);
		absorb_sample(s, l, closed, res);
		if (closed) begin
			if (use_typed) res = typed_stats.pop_front();
			pending_stats.push_back(res);
		end
		samples_sent++;
		@(negedge clk);
	endtask

	task automatic hold_until_drained();
		in_valid <= 1'b0;
		while (pending_stats.size() != 0) @(negedge clk);
	endtask

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	always @(posedge clk) begin
		stats_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_stats.size() == 0) begin
				report("unexpected transfer", 1, 0);
			end else begin
				want = pending_stats.pop_front();
				sets_checked++;
				if (count !== want.count) report("count", count, want.count);
				if (total !== want.total) report("total", total, want.total);
				if (square_total !== want.square_total)
					report("square_total", square_total, want.square_total);
				if (minimum !== want.minimum) report("minimum", minimum, want.minimum);
				if (maximum !== want.maximum) report("maximum", maximum, want.maximum);
				if (mean !== want.mean) report("mean", mean, want.mean);
				if (variance !== want.variance) report("variance", variance, want.variance);
				if (std_dev !== want.std_dev) report("std_dev", std_dev, want.std_dev);
				if (overflowed !== want.overflowed)
					report("overflowed", overflowed, want.overflowed);
			end
			stall_left <= rx_idle_on ? $urandom_range(0, 16) : 0;
		end
	end

	always @(negedge clk) begin
		if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left <= stall_left - 1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	initial begin
		row_t   rows[$];
		stats_t t;
		int     len;
		int     sent;
		logic signed [SAMPLE_W-1:0] s;
		clear_set();
		rows = '{
			'{16'sh7FFF, 1'b1, 1'b1},
			'{16'sh8000, 1'b1, 1'b1},
			'{16'sh0000, 1'b1, 1'b1},
			'{16'sh8000, 1'b0, 1'b0}, '{16'sh7FFF, 1'b1, 1'b0},
			'{16'sd3, 1'b0, 1'b0}, '{-16'sd5, 1'b0, 1'b0}, '{16'sd7, 1'b1, 1'b0},
			'{-16'sd1, 1'b0, 1'b0}, '{-16'sd2, 1'b1, 1'b0},
			'{16'sd1, 1'b0, 1'b0}, '{16'sd2, 1'b1, 1'b0},
			'{16'sh5555, 1'b0, 1'b0}, '{16'shAAAA, 1'b0, 1'b0}, '{16'sh0001, 1'b1, 1'b0}
		};
		t = '{count: 1, total: 32767, square_total: 1073676289, minimum: 16'sh7FFF,
			maximum: 16'sh7FFF, mean: 24'sd8388352, variance: 0, std_dev: 0, overflowed: 0};
		typed_stats.push_back(t);
		t = '{count: 1, total: -32768, square_total: 1073741824, minimum: 16'sh8000,
			maximum: 16'sh8000, mean: -24'sd8388608, variance: 0, std_dev: 0, overflowed: 0};
		typed_stats.push_back(t);
		t = '{count: 1, total: 0, square_total: 0, minimum: 0, maximum: 0,
			mean: 0, variance: 0, std_dev: 0, overflowed: 0};
		typed_stats.push_back(t);

		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (rows[i]) send_sample(rows[i].s, rows[i].l, rows[i].typed);
		hold_until_drained();

		// fill a set to capacity, then drop the closing sample
		rx_idle_on = 1'b0;
		tx_idle_on = 1'b0;
		repeat (SET_FULL) send_sample(SAMPLE_MOST_POS, 1'b0, 1'b0);
		t = '{count: 16'hFFFF, total: 2147385345, square_total: 46'd70363375599615,
			minimum: 16'sh7FFF, maximum: 16'sh7FFF, mean: 24'sd8388352,
			variance: 0, std_dev: 0, overflowed: 1};
		typed_stats.push_back(t);
		send_sample(16'sh8000, 1'b1, 1'b1);
		hold_until_drained();

		sent = 0;
		while (sent < 600) begin
			tx_idle_on = ($urandom_range(0, 3) != 0);
			rx_idle_on = ($urandom_range(0, 3) != 0);
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
			for (int k = 0; k < len; k++) begin
				case ($urandom_range(0, 7))
					0: s = SAMPLE_MOST_POS;
					1: s = SAMPLE_MOST_NEG;
					2: s = $signed(16'($urandom_range(0, 15))) - 16'sd8;
					default: s = $signed(16'($urandom()));
				endcase
				send_sample(s, k == len - 1, 1'b0);
				sent++;
			end
			if ($urandom_range(0, 19) == 0) hold_until_drained();
		end

		in_valid <= 1'b0;
		while (pending_stats.size() != 0) @(negedge clk);
		repeat (400) @(negedge clk);
		$display("Sent %0d samples, checked %0d result sets (extremes, full set with drop).",
			samples_sent, sets_checked);
		if (errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end
endmodule
